@@ hw/rtl/ols_pkg.sv @@
// Shared constants, types and control structs of the order list sanitizer.
package ols_pkg;

  localparam int MAX_ENTRIES = 32;
  localparam int ID_W        = 16;
  localparam int CMD_W       = 2;
  localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD    = 2'd0,
    CMD_REQUEST = 2'd1,
    CMD_FINISH  = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    EM_NONE  = 2'd0,
    EM_HIT   = 2'd1,
    EM_PEND  = 2'd2,
    EM_FINAL = 2'd3
  } emit_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_END  = 3'b100
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic  start;
    logic  advance;
    logic  set_taken;
    logic  load_pend;
    logic  append;
    logic  clear;
    emit_t emit;
  } ols_ctl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    cmd_t cmd;
    logic cmp_v;
    logic match;
    logic cmp_taken;
    logic scan_empty;
    logic pend_v;
    logic out_busy;
    logic full;
  } ols_sts_t;

endpackage

@@ hw/rtl/ols_in_if.sv @@
// Input channel: command and id words with a valid/ready handshake.
interface ols_in_if;
  import ols_pkg::*;

  logic            valid;
  logic            ready;
  logic [CMD_W-1:0] cmd;
  logic [ID_W-1:0] layer_id;

  modport source (output valid, output cmd, output layer_id, input ready);
  modport sink   (input valid, input cmd, input layer_id, output ready);
endinterface

@@ hw/rtl/ols_out_if.sv @@
// Result channel: sanitized id words with a valid/ready handshake.
interface ols_out_if;
  import ols_pkg::*;

  logic            valid;
  logic            ready;
  logic [ID_W-1:0] out_id;
  logic            last;
  logic            none_left;

  modport source (output valid, output out_id, output last, output none_left, input ready);
  modport sink   (input valid, input out_id, input last, input none_left, output ready);
endinterface

@@ hw/rtl/ols_ctrl.sv @@
// Controller state machine: sequences the table scan and result emission.
module ols_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  ols_pkg::ols_sts_t sts,
  output ols_pkg::ols_ctl_t ctl
);
  import ols_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt     = state_r;
    ctl.start     = 1'b0;
    ctl.advance   = 1'b0;
    ctl.set_taken = 1'b0;
    ctl.load_pend = 1'b0;
    ctl.append    = 1'b0;
    ctl.clear     = 1'b0;
    ctl.emit      = EM_NONE;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          ctl.start = 1'b1;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (sts.cmp_v) begin
          case (sts.cmd)
            CMD_LOAD: begin
              // A duplicate load ends the item without touching the table.
              if (sts.match) begin
                state_nxt = ST_IDLE;
              end else begin
                ctl.advance = 1'b1;
              end
            end
            CMD_REQUEST: begin
              if (sts.match) begin
                if (sts.cmp_taken) begin
                  state_nxt = ST_IDLE;
                end else if (!sts.out_busy) begin
                  ctl.emit      = EM_HIT;
                  ctl.set_taken = 1'b1;
                  state_nxt     = ST_IDLE;
                end
              end else begin
                ctl.advance = 1'b1;
              end
            end
            CMD_FINISH: begin
              // One leftover is held back so that the last one can be flagged.
              if (sts.cmp_taken) begin
                ctl.advance = 1'b1;
              end else if (!sts.pend_v) begin
                ctl.load_pend = 1'b1;
                ctl.advance   = 1'b1;
              end else if (!sts.out_busy) begin
                ctl.emit      = EM_PEND;
                ctl.load_pend = 1'b1;
                ctl.advance   = 1'b1;
              end
            end
            default: begin
              ctl.advance = 1'b1;
            end
          endcase
        end else if (sts.scan_empty) begin
          state_nxt = ST_END;
        end else begin
          ctl.advance = 1'b1;
        end
      end
      ST_END: begin
        case (sts.cmd)
          CMD_LOAD: begin
            ctl.append = !sts.full;
            state_nxt  = ST_IDLE;
          end
          CMD_FINISH: begin
            if (!sts.out_busy) begin
              ctl.emit  = EM_FINAL;
              ctl.clear = 1'b1;
              state_nxt = ST_IDLE;
            end
          end
          default: begin
            state_nxt = ST_IDLE;
          end
        endcase
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

@@ hw/rtl/ols_dp.sv @@
// Datapath: id memory, taken marks, scan pipeline, pending leftover and output register.
module ols_dp (
  input  logic                     clk,
  input  logic                     rst_n,
  input  ols_pkg::ols_ctl_t        ctl,
  output ols_pkg::ols_sts_t        sts,
  input  logic [ols_pkg::CMD_W-1:0] in_cmd,
  input  logic [ols_pkg::ID_W-1:0] in_layer_id,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [ols_pkg::ID_W-1:0] out_id,
  output logic                     out_last,
  output logic                     out_none_left
);
  import ols_pkg::*;

  logic [ID_W-1:0]        mem [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0] taken_r;
  logic [CNT_W-1:0]       count_r;
  logic [CNT_W-1:0]       rd_idx_r;
  logic [IDX_W-1:0]       cmp_idx_r;
  logic                   cmp_v_r;
  logic [ID_W-1:0]        rd_data_r;
  cmd_t                   cmd_r;
  logic [ID_W-1:0]        id_r;
  logic                   pend_v_r;
  logic [ID_W-1:0]        pend_id_r;
  logic                   out_valid_r;
  logic [ID_W-1:0]        out_id_r;
  logic                   out_last_r;
  logic                   out_none_r;
  logic                   issue;
  logic                   out_free;

  assign issue    = ctl.advance && (rd_idx_r < count_r);
  assign out_free = !out_valid_r || out_ready;

  assign sts.cmd        = cmd_r;
  assign sts.cmp_v      = cmp_v_r;
  assign sts.match      = (rd_data_r == id_r);
  assign sts.cmp_taken  = taken_r[cmp_idx_r];
  assign sts.scan_empty = !(rd_idx_r < count_r);
  assign sts.pend_v     = pend_v_r;
  assign sts.out_busy   = !out_free;
  assign sts.full       = (count_r == CNT_W'(MAX_ENTRIES));

  // Id memory: one write port for appends, one registered read port for the scan.
  always_ff @(posedge clk) begin
    if (ctl.append) begin
      mem[count_r[IDX_W-1:0]] <= id_r;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      rd_data_r <= mem[rd_idx_r[IDX_W-1:0]];
      cmp_idx_r <= rd_idx_r[IDX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      cmd_r <= cmd_t'(in_cmd);
      id_r  <= in_layer_id;
    end
    if (ctl.load_pend) begin
      pend_id_r <= rd_data_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      taken_r  <= '0;
      rd_idx_r <= '0;
      cmp_v_r  <= 1'b0;
      pend_v_r <= 1'b0;
    end else begin
      if (ctl.start) begin
        rd_idx_r <= '0;
        cmp_v_r  <= 1'b0;
        pend_v_r <= 1'b0;
      end else if (ctl.advance) begin
        cmp_v_r <= issue;
        if (issue) begin
          rd_idx_r <= rd_idx_r + CNT_W'(1);
        end
      end
      if (ctl.load_pend) begin
        pend_v_r <= 1'b1;
      end
      if (ctl.set_taken) begin
        taken_r[cmp_idx_r] <= 1'b1;
      end
      if (ctl.append) begin
        count_r <= count_r + CNT_W'(1);
      end
      if (ctl.clear) begin
        count_r  <= '0;
        taken_r  <= '0;
        pend_v_r <= 1'b0;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.emit != EM_NONE) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (ctl.emit)
      EM_HIT: begin
        out_id_r   <= id_r;
        out_last_r <= 1'b0;
        out_none_r <= 1'b0;
      end
      EM_PEND: begin
        out_id_r   <= pend_id_r;
        out_last_r <= 1'b0;
        out_none_r <= 1'b0;
      end
      EM_FINAL: begin
        out_id_r   <= pend_v_r ? pend_id_r : '0;
        out_last_r <= 1'b1;
        out_none_r <= !pend_v_r;
      end
      default: begin
      end
    endcase
  end

  assign out_valid     = out_valid_r;
  assign out_id        = out_id_r;
  assign out_last      = out_last_r;
  assign out_none_left = out_none_r;

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.emit != EM_NONE) |-> out_free)
    else $error("result written while the output register is still held");

  a_taken_once: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.set_taken |-> (cmp_v_r && !taken_r[cmp_idx_r]))
    else $error("taken mark set on an invalid or already taken entry");

  a_append_room: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.append |-> (count_r < CNT_W'(MAX_ENTRIES)))
    else $error("append into a full table");

  a_clear_done: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.clear |=> ((count_r == '0) && (taken_r == '0) && !pend_v_r))
    else $error("table not cleared after finish");

  a_taken_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.set_taken |-> (CNT_W'(cmp_idx_r) < count_r))
    else $error("taken mark set beyond the stored entries");

endmodule

@@ hw/rtl/order_list_sanitizer.sv @@
// Top level of the order list sanitizer: controller plus datapath behind two channels.
//
//   channel  direction  word fields                    handshake
//   in_ch    sink       cmd, layer_id                  valid / ready
//   out_ch   source     out_id, last, none_left        valid / ready
//
// One item at a time. Load, request and unused-command items walk the whole table from
// one accept to the next, stopping early when a request or duplicate load hits; a
// request that hits also waits while the output register is still held, and a finish
// also waits while the result channel stalls. The scan is paced by the single
// registered read port of the id memory, which the scan walks one entry per cycle
// except while it waits on a held result.
// Reset (rst_n low, synchronous) empties the table and clears all taken marks.
// A stalled result is held in the output register while the scan waits on it.
module order_list_sanitizer (
  input  logic       clk,
  input  logic       rst_n,
  ols_in_if.sink     in_ch,
  ols_out_if.source  out_ch
);
  import ols_pkg::*;

  ols_ctl_t ctl;
  ols_sts_t sts;

  ols_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .ctl      (ctl)
  );

  ols_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .ctl           (ctl),
    .sts           (sts),
    .in_cmd        (in_ch.cmd),
    .in_layer_id   (in_ch.layer_id),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .out_id        (out_ch.out_id),
    .out_last      (out_ch.last),
    .out_none_left (out_ch.none_left)
  );

endmodule
